[hw/rtl/gdd_pkg.sv]
// shared types, constants and month tables for the gregorian date difference block
// no dependencies

package gdd_pkg;

  localparam logic [13:0] MAX_YEAR      = 14'd9999;
  // multiplier for a divide by 25 of a 12-bit value, exact below 4681
  localparam logic [11:0] DIV25_MUL     = 12'd2622;
  localparam int unsigned DIV25_SHIFT   = 16;
  localparam logic [11:0] QUARTERS_CENT = 12'd25;
  localparam logic [21:0] DAYS_PER_YEAR = 22'd365;

  localparam logic [1:0] ORD_EQUAL        = 2'd0;
  localparam logic [1:0] ORD_FIRST_LATER  = 2'd1;
  localparam logic [1:0] ORD_SECOND_LATER = 2'd2;

  typedef struct packed {
    logic [4:0]  first_day;
    logic [3:0]  first_month;
    logic [13:0] first_year;
    logic [4:0]  second_day;
    logic [3:0]  second_month;
    logic [13:0] second_year;
  } gdd_in_t;

  typedef struct packed {
    logic [21:0] day_distance;
    logic [1:0]  order;
    logic        first_is_leap;
  } gdd_out_t;

  // days of the whole months before month m in a common year
  function automatic logic [8:0] month_days_before(input logic [3:0] m);
    logic [8:0] d;
    unique case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      4'd13:   d = 9'd365;
      4'd14:   d = 9'd393;
      default: d = 9'd421;
    endcase
    return d;
  endfunction

  // february-like months before month m, each adding a day in a leap year
  function automatic logic [1:0] leap_months_before(input logic [3:0] m);
    logic [1:0] n;
    if (m < 4'd3) begin
      n = 2'd0;
    end else if (m < 4'd14) begin
      n = 2'd1;
    end else if (m == 4'd14) begin
      n = 2'd2;
    end else begin
      n = 2'd3;
    end
    return n;
  endfunction

endpackage

[hw/rtl/gdd_lane.sv]
// one lane: turns a date into its serial day number and leap flag in two stages
// depends on gdd_pkg

module gdd_lane
  import gdd_pkg::*;
(
  input  logic        clk,
  input  logic [4:0]  day,
  input  logic [3:0]  month,
  input  logic [13:0] year,
  output logic [21:0] serial,
  output logic        leap
);

  // stage 1: clamp year, reciprocal products for the century counts
  logic [13:0] yc;
  logic [13:0] p;
  logic [23:0] prod_p;
  logic [23:0] prod_y;

  logic [4:0]  day_r;
  logic [3:0]  month_r;
  logic [13:0] yc_r;
  logic [13:0] p_r;
  logic [23:0] prod_p_r;
  logic [23:0] prod_y_r;

  assign yc     = (year > MAX_YEAR) ? MAX_YEAR : year;
  // year zero counts no whole years, same as year one
  assign p      = (yc == 14'd0) ? 14'd0 : yc - 14'd1;
  assign prod_p = 24'(p[13:2]) * 24'(DIV25_MUL);
  assign prod_y = 24'(yc[13:2]) * 24'(DIV25_MUL);

  always_ff @(posedge clk) begin
    day_r    <= day;
    month_r  <= month;
    yc_r     <= yc;
    p_r      <= p;
    prod_p_r <= prod_p;
    prod_y_r <= prod_y;
  end

  // stage 2: year part, month part, day
  logic [6:0]  cent_p;
  logic [4:0]  quad_cent_p;
  logic [6:0]  cent_y;
  logic        div4;
  logic        div100;
  logic        div400;
  logic        leap_s2;
  logic [21:0] year_days;
  logic [21:0] serial_nxt;

  assign cent_p      = prod_p_r[DIV25_SHIFT +: 7];
  assign quad_cent_p = cent_p[6:2];
  assign cent_y      = prod_y_r[DIV25_SHIFT +: 7];

  assign div4    = (yc_r[1:0] == 2'd0);
  assign div100  = div4 && (yc_r[13:2] == 12'(12'(cent_y) * QUARTERS_CENT));
  assign div400  = div100 && (cent_y[1:0] == 2'd0);
  assign leap_s2 = div400 || (div4 && !div100);

  assign year_days = 22'(p_r) * DAYS_PER_YEAR + 22'(p_r[13:2]) - 22'(cent_p)
                   + 22'(quad_cent_p);

  assign serial_nxt = year_days + 22'(month_days_before(month_r))
                    + (leap_s2 ? 22'(leap_months_before(month_r)) : 22'd0)
                    + 22'(day_r);

  always_ff @(posedge clk) begin
    serial <= serial_nxt;
    leap   <= leap_s2;
  end

endmodule

[hw/rtl/gdd_merge.sv]
// merge stage: compares the two lanes' serial numbers and registers the result
// depends on gdd_pkg

module gdd_merge
  import gdd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        valid,
  input  logic [21:0] serial_a,
  input  logic [21:0] serial_b,
  input  logic        leap_a,
  output logic        out_valid,
  output gdd_out_t    out_data
);

  logic     out_valid_r;
  gdd_out_t out_data_r;
  gdd_out_t out_data_nxt;

  always_comb begin
    out_data_nxt.first_is_leap = leap_a;
    priority if (serial_a > serial_b) begin
      out_data_nxt.day_distance = serial_a - serial_b;
      out_data_nxt.order        = ORD_FIRST_LATER;
    end else if (serial_a < serial_b) begin
      out_data_nxt.day_distance = serial_b - serial_a;
      out_data_nxt.order        = ORD_SECOND_LATER;
    end else begin
      out_data_nxt.day_distance = 22'd0;
      out_data_nxt.order        = ORD_EQUAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= valid;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hw/rtl/gregorian_date_difference.sv]
// top level of the gregorian date difference block: two date lanes and a merge stage
// depends on gdd_pkg, gdd_lane, gdd_merge

// Takes one item a cycle: a transfer happens at every clock edge with start high, since busy
// is tied low and never stalls the input. Each item carries two proleptic Gregorian dates;
// each goes to its own lane, which turns it into a serial day number over two registered
// stages (reciprocal multiplies for the century counts, then the sum of year, month and day
// parts). The merge stage compares the two numbers and registers the distance, the order
// and the first date's leap flag. Each result goes through both lane registers and the merge
// register to out_data, marked by out_valid for one cycle; the receiver cannot stall, so results
// must be taken when shown. Years above 9999 are clamped, month and day are used unchecked.

module gregorian_date_difference
  import gdd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  gdd_in_t  in_data,
  output logic     out_valid,
  output gdd_out_t out_data
);

  // no loop-carried state, so the block never holds off the input
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // valid tracking through the two lane stages
  logic v1_r;
  logic v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
    end
  end

  logic [21:0] serial_first;
  logic [21:0] serial_second;
  logic        leap_first;
  logic        leap_second;

  // lane for the first date
  gdd_lane u_lane_first (
    .clk    (clk),
    .day    (in_data.first_day),
    .month  (in_data.first_month),
    .year   (in_data.first_year),
    .serial (serial_first),
    .leap   (leap_first)
  );

  // lane for the second date, its leap flag is not reported
  gdd_lane u_lane_second (
    .clk    (clk),
    .day    (in_data.second_day),
    .month  (in_data.second_month),
    .year   (in_data.second_year),
    .serial (serial_second),
    .leap   (leap_second)
  );

  logic unused_leap;
  assign unused_leap = leap_second;

  // compare, subtract and register the result
  gdd_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid     (v2_r && !unused_leap || v2_r),
    .serial_a  (serial_first),
    .serial_b  (serial_second),
    .leap_a    (leap_first),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
